/* sv/ccc_pkg.sv */
`default_nettype none

package ccc_pkg;

   localparam int unsigned YearWidth   = 7;
   localparam int unsigned MonthWidth  = 4;
   localparam int unsigned DayWidth    = 5;
   localparam int unsigned HoursWidth  = 5;
   localparam int unsigned MinuteWidth = 6;
   localparam int unsigned SecondWidth = 6;

   localparam logic [YearWidth-1:0]   YEAR_LAST   = 7'd99;
   localparam logic [MonthWidth-1:0]  MONTH_FIRST = 4'd1;
   localparam logic [MonthWidth-1:0]  MONTH_LAST  = 4'd12;
   localparam logic [MonthWidth-1:0]  MONTH_FEB   = 4'd2;
   localparam logic [DayWidth-1:0]    DAY_FIRST   = 5'd1;
   localparam logic [DayWidth-1:0]    DAY_LAST    = 5'd31;
   localparam logic [DayWidth-1:0]    DAY_LEAP    = 5'd29;
   localparam logic [HoursWidth-1:0]  HOURS_LAST  = 5'd23;
   localparam logic [MinuteWidth-1:0] MINUTE_LAST = 6'd59;
   localparam logic [SecondWidth-1:0] SECOND_LAST = 6'd59;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } ccc_cmd_type;

   typedef struct packed {
      ccc_cmd_type            cmd;
      logic [YearWidth-1:0]   set_year;
      logic [MonthWidth-1:0]  set_month;
      logic [DayWidth-1:0]    set_day;
      logic [HoursWidth-1:0]  set_hours;
      logic [MinuteWidth-1:0] set_minutes;
      logic [SecondWidth-1:0] set_seconds;
   } ccc_req_type;

   typedef struct packed {
      logic [YearWidth-1:0]   year_now;
      logic [MonthWidth-1:0]  month_now;
      logic [DayWidth-1:0]    day_now;
      logic [HoursWidth-1:0]  hours_now;
      logic [MinuteWidth-1:0] minutes_now;
      logic [SecondWidth-1:0] seconds_now;
      logic                   time_valid;
   } ccc_rsp_type;

   typedef struct packed {
      logic [YearWidth-1:0]   year;
      logic [MonthWidth-1:0]  month;
      logic [DayWidth-1:0]    day;
      logic [HoursWidth-1:0]  hours;
      logic [MinuteWidth-1:0] minutes;
      logic [SecondWidth-1:0] seconds;
   } ccc_time_type;

   localparam ccc_time_type TIME_RESET = '{
      year:    '0,
      month:   MONTH_FIRST,
      day:     DAY_FIRST,
      hours:   '0,
      minutes: '0,
      seconds: '0
   };

   function automatic logic time_ok(input ccc_time_type t);
      return (t.month >= MONTH_FIRST) && (t.month <= MONTH_LAST) &&
             (t.day >= DAY_FIRST) && (t.day <= DAY_LAST) &&
             (t.hours <= HOURS_LAST) &&
             (t.minutes <= MINUTE_LAST) &&
             (t.seconds <= SECOND_LAST);
   endfunction

   // Length of a month; leap February when year mod 4 is zero.
   function automatic logic [DayWidth-1:0] month_days(input logic [MonthWidth-1:0] month,
                                                      input logic [YearWidth-1:0]  year);
      logic [DayWidth-1:0] len;
      begin
         case (month)
            MONTH_FEB:           len = (year[1:0] == 2'b00) ? DAY_LEAP : 5'd28;
            4'd4, 4'd6, 4'd9,
            4'd11:               len = 5'd30;
            default:             len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

`default_nettype wire

/* sv/calendar_clock_counter.sv */
`default_nettype none

// Calendar clock counter. Holds year (two digits), month, day, hours,
// minutes and seconds. A load transaction (cmd = 1) writes all six fields as
// given, legal or not; a tick transaction (cmd = 0) advances the time by one
// second with full rollover through days of the month (29-day February when
// year mod 4 is zero) and years (99 wraps to 0). A tick on an illegal time
// leaves it unchanged. Every request transaction yields exactly one response
// transaction carrying the time after that request and a time_valid flag
// (month 1..12, day 1..31, hours <= 23, minutes and seconds <= 59; the year
// is not checked). The response is registered: one request is taken every
// cycle while req_ready is high, and the whole update is one compare-
// and-increment pass between the time register and the response register.
// A two-entry output stage (response register plus skid register) keeps
// req_ready registered; it drops only when both entries hold responses.
// Reset time: year 0, month 1, day 1, 00:00:00.
module calendar_clock_counter (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire ccc_pkg::ccc_req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ccc_pkg::ccc_rsp_type  rsp_data
);

   // Current time
   ccc_pkg::ccc_time_type time_ff;
   ccc_pkg::ccc_time_type time_in;

   // Output stage
   ccc_pkg::ccc_rsp_type  rsp_ff;
   ccc_pkg::ccc_rsp_type  rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   ccc_pkg::ccc_rsp_type  skid_ff;
   ccc_pkg::ccc_rsp_type  skid_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;

   logic                  req_take;
   logic                  rsp_take;
   ccc_pkg::ccc_time_type tick_time;
   ccc_pkg::ccc_rsp_type  new_rsp;

   // Cascade carries
   logic                  sec_wrap;
   logic                  min_wrap;
   logic                  hour_wrap;
   logic                  day_wrap;
   logic                  month_wrap;
   logic [ccc_pkg::DayWidth:0] day_inc;

   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // One-second advance. Each carry only matters when every lower field
   // wraps; the limits assume a legal time, which a tick requires anyway.
   always_comb begin
      sec_wrap   = (time_ff.seconds == ccc_pkg::SECOND_LAST);
      min_wrap   = sec_wrap && (time_ff.minutes == ccc_pkg::MINUTE_LAST);
      hour_wrap  = min_wrap && (time_ff.hours == ccc_pkg::HOURS_LAST);
      day_inc    = {1'b0, time_ff.day} + 6'd1;
      // A day past its month (e.g. the 31st of April) also rolls over here.
      day_wrap   = hour_wrap &&
                   (day_inc > {1'b0, ccc_pkg::month_days(time_ff.month, time_ff.year)});
      month_wrap = day_wrap && (time_ff.month >= ccc_pkg::MONTH_LAST);

      tick_time = time_ff;
      tick_time.seconds = sec_wrap ? '0 : time_ff.seconds + 6'd1;
      if (sec_wrap) begin
         tick_time.minutes = min_wrap ? '0 : time_ff.minutes + 6'd1;
      end
      if (min_wrap) begin
         tick_time.hours = hour_wrap ? '0 : time_ff.hours + 5'd1;
      end
      if (hour_wrap) begin
         tick_time.day = day_wrap ? ccc_pkg::DAY_FIRST : day_inc[ccc_pkg::DayWidth-1:0];
      end
      if (day_wrap) begin
         tick_time.month = month_wrap ? ccc_pkg::MONTH_FIRST : time_ff.month + 4'd1;
      end
      if (month_wrap) begin
         // Loaded years above 99 wrap as well.
         tick_time.year = (time_ff.year >= ccc_pkg::YEAR_LAST) ? '0 : time_ff.year + 7'd1;
      end
   end

   // Next time for an accepted request
   always_comb begin
      time_in = time_ff;
      if (req_take) begin
         if (req_data.cmd == ccc_pkg::CMD_LOAD) begin
            time_in.year    = req_data.set_year;
            time_in.month   = req_data.set_month;
            time_in.day     = req_data.set_day;
            time_in.hours   = req_data.set_hours;
            time_in.minutes = req_data.set_minutes;
            time_in.seconds = req_data.set_seconds;
         end else if (ccc_pkg::time_ok(time_ff)) begin
            time_in = tick_time;
         end
      end
   end

   always_comb begin
      new_rsp.year_now    = time_in.year;
      new_rsp.month_now   = time_in.month;
      new_rsp.day_now     = time_in.day;
      new_rsp.hours_now   = time_in.hours;
      new_rsp.minutes_now = time_in.minutes;
      new_rsp.seconds_now = time_in.seconds;
      new_rsp.time_valid  = ccc_pkg::time_ok(time_in);
   end

   // Output register plus skid entry; the skid only fills when a new
   // response arrives while the held one is stalled.
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_in       = new_rsp;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= ccc_pkg::TIME_RESET;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         time_ff       <= time_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

`ifndef NO_ASSERTIONS
   // The skid entry never holds a response without the output register full.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while output register empty");

   // Every accepted request leaves a response pending next cycle.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // A tick never turns a legal time into an illegal one.
   a_tick_keeps_legal: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_data.cmd == ccc_pkg::CMD_TICK) && ccc_pkg::time_ok(time_ff))
      |=> ccc_pkg::time_ok(time_ff))
      else $error("tick produced an illegal time");

   // An illegal time is frozen across a tick.
   a_tick_freezes_illegal: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_data.cmd == ccc_pkg::CMD_TICK) && !ccc_pkg::time_ok(time_ff))
      |=> $stable(time_ff))
      else $error("tick changed an illegal time");
`endif

endmodule

`default_nettype wire

/* tb/sv/calendar_clock_counter_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the calendar time and
// compares every response transaction against the predicted reading.
module calendar_clock_counter_checker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_ready,
   input  ccc_pkg::ccc_req_type req_data,
   input  wire                  rsp_valid,
   input  wire                  rsp_ready,
   input  ccc_pkg::ccc_rsp_type rsp_data,
   output int                   mismatch_count,
   output int                   readings_pending
);

   localparam int LastSecond = 59;
   localparam int LastMinute = 59;
   localparam int LastHour   = 23;
   localparam int LastDay    = 31;
   localparam int LastMonth  = 12;
   localparam int LastYear   = 99;
   localparam int February   = 2;

   ccc_pkg::ccc_time_type held_time;
   ccc_pkg::ccc_rsp_type  clock_readings[$];

   function automatic int month_length(input int month, input int year);
      case (month)
         February:    return (year % 4 == 0) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // Year is never range checked.
   function automatic logic legal_time(input ccc_pkg::ccc_time_type t);
      return t.month >= 1 && t.month <= LastMonth && t.day >= 1 && t.day <= LastDay &&
             t.hours <= LastHour && t.minutes <= LastMinute && t.seconds <= LastSecond;
   endfunction

   // Only called on a legal time. A day past its month (April 31) rolls over too.
   function automatic ccc_pkg::ccc_time_type step_one_second(input ccc_pkg::ccc_time_type t);
      ccc_pkg::ccc_time_type n;
      n = t;
      if (n.seconds < LastSecond) begin
         n.seconds = n.seconds + 6'd1;
         return n;
      end
      n.seconds = '0;
      if (n.minutes < LastMinute) begin
         n.minutes = n.minutes + 6'd1;
         return n;
      end
      n.minutes = '0;
      if (n.hours < LastHour) begin
         n.hours = n.hours + 5'd1;
         return n;
      end
      n.hours = '0;
      if (int'(n.day) < month_length(int'(n.month), int'(n.year))) begin
         n.day = n.day + 5'd1;
         return n;
      end
      n.day = 5'd1;
      if (n.month < LastMonth) begin
         n.month = n.month + 4'd1;
         return n;
      end
      n.month = 4'd1;
      n.year  = (n.year >= LastYear) ? '0 : n.year + 7'd1;
      return n;
   endfunction

   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      ccc_pkg::ccc_rsp_type reading;
      if (reset) begin
         held_time.year    = '0;
         held_time.month   = 4'd1;
         held_time.day     = 5'd1;
         held_time.hours   = '0;
         held_time.minutes = '0;
         held_time.seconds = '0;
         clock_readings.delete();
         mismatch_count = 0;
      end else begin
         // response first: it always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (clock_readings.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               reading = clock_readings.pop_front();
               report_field("year_now", 8'(reading.year_now), 8'(rsp_data.year_now));
               report_field("month_now", 8'(reading.month_now), 8'(rsp_data.month_now));
               report_field("day_now", 8'(reading.day_now), 8'(rsp_data.day_now));
               report_field("hours_now", 8'(reading.hours_now), 8'(rsp_data.hours_now));
               report_field("minutes_now", 8'(reading.minutes_now),
                            8'(rsp_data.minutes_now));
               report_field("seconds_now", 8'(reading.seconds_now),
                            8'(rsp_data.seconds_now));
               report_field("time_valid", 8'(reading.time_valid), 8'(rsp_data.time_valid));
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.cmd == ccc_pkg::CMD_LOAD) begin
               held_time.year    = req_data.set_year;
               held_time.month   = req_data.set_month;
               held_time.day     = req_data.set_day;
               held_time.hours   = req_data.set_hours;
               held_time.minutes = req_data.set_minutes;
               held_time.seconds = req_data.set_seconds;
            end else if (legal_time(held_time)) begin
               held_time = step_one_second(held_time);
            end
            reading.year_now    = held_time.year;
            reading.month_now   = held_time.month;
            reading.day_now     = held_time.day;
            reading.hours_now   = held_time.hours;
            reading.minutes_now = held_time.minutes;
            reading.seconds_now = held_time.seconds;
            reading.time_valid  = legal_time(held_time);
            clock_readings.push_back(reading);
         end
      end
      readings_pending = clock_readings.size();
   end

endmodule

/* tb/sv/calendar_clock_counter_test.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the calendar clock counter. All prediction and
// comparison lives in the checker instance; this module only drives
// request transactions, throttles the response side and decides the outcome.
module calendar_clock_counter_test;

   localparam int ItemsTarget = 1400;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   ccc_pkg::ccc_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   ccc_pkg::ccc_rsp_type rsp_data;

   int mismatch_count;
   int readings_pending;
   int items_sent = 0;
   int calm_left  = 0;   // request transactions still to go back to back

   calendar_clock_counter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   calendar_clock_counter_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. Worst case is roughly 1400 transactions, each behind a long
   // response stall; the timeout leaves several times that.
   initial begin
      #6_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Response side: ready dropped for short or long stretches, with calm
   // stretches where it stays high so back-to-back responses happen too.
   initial begin : response_throttle
      int stall_left;
      int quiet_left;
      int roll;
      stall_left = 0;
      quiet_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready  = 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_ready = 1'b1;
            if (quiet_left > 0) begin
               quiet_left = quiet_left - 1;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 2)
                  quiet_left = $urandom_range(30, 120);
               else if (roll < 25)
                  stall_left = $urandom_range(1, 3);
               else if (roll < 29)
                  stall_left = $urandom_range(8, 40);
            end
         end
      end
   end

   // Drives one request transaction, called at a falling edge. A random gap
   // lowers valid first; with no gap valid stays high from the previous
   // transaction and only the payload changes. Returns at the falling edge
   // after the accepting rising edge, with valid still high.
   task automatic send_item(input ccc_pkg::ccc_req_type item);
      int gap;
      int roll;
      if (calm_left > 0) begin
         calm_left = calm_left - 1;
         gap = 0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            calm_left = $urandom_range(20, 80);
         if (roll < 55)
            gap = 0;
         else if (roll < 90)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_load(input int year, input int month, input int day,
                            input int hours, input int minutes, input int seconds);
      ccc_pkg::ccc_req_type item;
      item.cmd         = ccc_pkg::CMD_LOAD;
      item.set_year    = 7'(year);
      item.set_month   = 4'(month);
      item.set_day     = 5'(day);
      item.set_hours   = 5'(hours);
      item.set_minutes = 6'(minutes);
      item.set_seconds = 6'(seconds);
      send_item(item);
   endtask

   // Set fields carry junk on a tick; the block must ignore them.
   task automatic send_tick();
      ccc_pkg::ccc_req_type item;
      item.cmd         = ccc_pkg::CMD_TICK;
      item.set_year    = 7'($urandom);
      item.set_month   = 4'($urandom);
      item.set_day     = 5'($urandom);
      item.set_hours   = 5'($urandom);
      item.set_minutes = 6'($urandom);
      item.set_seconds = 6'($urandom);
      send_item(item);
   endtask

   initial begin : stimulus
      int  pick;
      int  ticks;
      int  year;
      int  month;
      int  day;
      int  hours;
      int  minutes;
      int  seconds;
      bit  drained;
      drained   = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      send_tick();                              // first tick from reset time
      send_load(99, 12, 31, 23, 59, 59);        // full cascade, year 99 wraps to 0
      send_tick();
      send_load(4, 2, 28, 23, 59, 59);          // leap year: Feb 28 -> Feb 29
      send_tick();
      send_load(4, 2, 29, 23, 59, 59);          // leap Feb 29 -> Mar 1
      send_tick();
      send_load(3, 2, 28, 23, 59, 59);          // common year: Feb 28 -> Mar 1
      send_tick();
      send_load(21, 4, 31, 23, 59, 59);         // day past end of April still rolls
      send_tick();
      send_load(21, 6, 30, 22, 59, 59);         // hour carry only
      send_tick();
      send_load(50, 0, 15, 10, 10, 10);         // month zero: tick must freeze time
      send_tick();
      send_load(99, 15, 31, 31, 63, 63);        // every field but the year at its top value
      send_tick();
      send_load(0, 0, 0, 0, 0, 0);              // every field at zero
      send_load(7, 3, 0, 12, 0, 0);             // day zero
      send_load(7, 3, 9, 24, 0, 0);             // hour just past range
      send_load(7, 3, 9, 5, 0, 60);             // second just past range
      send_tick();

      // ---- random part ----
      // Mostly loads of a legal time close to a rollover followed by a run
      // of ticks; some loads of arbitrary field values; some bare tick runs.
      while (items_sent < ItemsTarget) begin
         if (!drained && items_sent >= ItemsTarget / 2) begin
            // hold off until every outstanding response has come back
            req_valid = 1'b0;
            while (readings_pending != 0) @(negedge clock);
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            year = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
            case ($urandom_range(0, 3))
               0:       month = 2;
               1:       month = 12;
               default: month = $urandom_range(1, 12);
            endcase
            day     = ($urandom_range(0, 3) != 0) ? $urandom_range(27, 31) : $urandom_range(1, 31);
            hours   = ($urandom_range(0, 3) != 0) ? 23 : $urandom_range(0, 23);
            minutes = ($urandom_range(0, 3) != 0) ? 59 : $urandom_range(0, 59);
            seconds = ($urandom_range(0, 3) != 0) ? $urandom_range(35, 59) : $urandom_range(0, 59);
            send_load(year, month, day, hours, minutes, seconds);
            ticks = $urandom_range(1, 25);
         end else if (pick < 85) begin
            send_load($urandom_range(0, 99), $urandom_range(0, 15), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
            ticks = $urandom_range(1, 4);
         end else begin
            ticks = $urandom_range(1, 10);
         end
         repeat (ticks) send_tick();
      end

      // ---- drain and verdict ----
      req_valid = 1'b0;
      while (readings_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);   // catch any stray response after the last one
      if (mismatch_count == 0 && readings_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* calendar_clock_counter.f */
sv/ccc_pkg.sv
sv/calendar_clock_counter.sv
tb/sv/calendar_clock_counter_checker.sv
tb/sv/calendar_clock_counter_test.sv
